>>> hw/rtl/sorted_table_floor_search_macros.svh
// Assertion macros for the checker file sts_check.sv.
// Each macro expects signals named clock and reset in scope.
`ifndef SORTED_TABLE_FLOOR_SEARCH_MACROS_SVH
`define SORTED_TABLE_FLOOR_SEARCH_MACROS_SVH

// Same-cycle implication
`define STS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define STS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/sts_pkg.sv
package sts_pkg;

   // Fixed field widths
   localparam int IDX_BITS   = 7;
   localparam int CODE_BITS  = 12;
   localparam int LEN_BITS   = 8;
   localparam int RES_BITS   = 8;
   localparam int REQ_DATA_W = 32;

   // Search bound width: holds -1 .. 256 signed
   localparam int LH_W = 11;

   localparam logic [LEN_BITS-1:0] LEN_RESET = 8'd128;

   // Command codes carried in tuser
   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_LOAD   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_PROBE = 3'b010,
      ST_DONE  = 3'b100
   } search_state_type;

   // Status from the search sequencer to the top level
   typedef struct packed {
      logic                idle;
      logic                done;
      logic [RES_BITS-1:0] index;
   } search_stat_type;

endpackage

>>> hw/rtl/sts_ram.sv
module sts_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wen,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/sts_search.sv
module sts_search #(
   parameter int TABLE_DEPTH = 128,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [SAMPLE_BITS-1:0]         key,
   input  logic [sts_pkg::LH_W-1:0]       length,
   input  logic                           out_free,
   input  logic [SAMPLE_BITS-1:0]         rdata,
   output logic [$clog2(TABLE_DEPTH)-1:0] raddr,
   output sts_pkg::search_stat_type       stat
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);

   sts_pkg::search_state_type state_ff, state_in;
   logic signed [sts_pkg::LH_W-1:0] lo_ff, lo_in;
   logic signed [sts_pkg::LH_W-1:0] hi_ff, hi_in;
   logic signed [sts_pkg::LH_W-1:0] mid_ff, mid_in;
   logic [SAMPLE_BITS-1:0]          key_ff, key_in;
   logic [sts_pkg::RES_BITS-1:0]    res_ff, res_in;
   logic signed [sts_pkg::LH_W-1:0] sum;
   logic                            less, greater;

   // compare the entry that came back for the current midpoint
   assign less    = rdata < key_ff;
   assign greater = rdata > key_ff;

   // one probe per cycle: next midpoint goes straight to the read address
   always_comb begin
      state_in = state_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      key_in   = key_ff;
      res_in   = res_ff;
      sum      = '0;
      case (state_ff)
         sts_pkg::ST_IDLE: begin
            if (start) begin
               key_in = key;
               lo_in  = '0;
               hi_in  = $signed(length) - sts_pkg::LH_W'(1);
               sum    = lo_in + hi_in;
               mid_in = sum >>> 1;
               if (hi_in < 0) begin
                  res_in   = hi_in[sts_pkg::RES_BITS-1:0];
                  state_in = sts_pkg::ST_DONE;
               end else begin
                  state_in = sts_pkg::ST_PROBE;
               end
            end
         end
         sts_pkg::ST_PROBE: begin
            if (less) begin
               lo_in = mid_ff + sts_pkg::LH_W'(1);
            end else if (greater) begin
               hi_in = mid_ff - sts_pkg::LH_W'(1);
            end
            sum    = lo_in + hi_in;
            mid_in = sum >>> 1;
            if (!less && !greater) begin
               res_in   = mid_ff[sts_pkg::RES_BITS-1:0];
               state_in = sts_pkg::ST_DONE;
            end else if (lo_in > hi_in) begin
               res_in   = hi_in[sts_pkg::RES_BITS-1:0];
               state_in = sts_pkg::ST_DONE;
            end
         end
         sts_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = sts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sts_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sts_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      key_ff <= key_in;
      res_ff <= res_in;
   end

   assign raddr      = ADDR_W'(mid_in);
   assign stat.idle  = (state_ff == sts_pkg::ST_IDLE);
   assign stat.done  = (state_ff == sts_pkg::ST_DONE);
   assign stat.index = res_ff;

endmodule

>>> hw/rtl/sorted_table_floor_search.sv
// Load beat: written to the table at acceptance, no result, next beat taken next cycle.
// Lookup beat: one table probe per cycle, at most ceil(log2(n+1)) probes for n entries
// in use (8 for 128), none at zero length; after the last probe the search waits in its
// done state until the result channel is free, then loads the result register; the next
// beat is taken after that. Throughput is set by the probe loop and result back-pressure.
// Synchronous active-high reset: length returns to 128, table contents undefined until loaded.
module sorted_table_floor_search #(
   parameter int TABLE_DEPTH = 128,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [sts_pkg::REQ_DATA_W-1:0]        req_tdata,  // entry_index, entry_value, sample
   input  logic                                  req_tuser,  // command
   // result channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [sts_pkg::RES_BITS-1:0]          rsp_tdata,  // table_index
   // length register
   input  logic                                  csr_wen,
   input  logic [sts_pkg::LEN_BITS-1:0]          csr_wdata
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);

   logic [sts_pkg::LEN_BITS-1:0]  len_ff, len_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [sts_pkg::RES_BITS-1:0]  rsp_index_ff, rsp_index_in;
   logic [sts_pkg::IDX_BITS-1:0]  entry_index;
   logic [sts_pkg::CODE_BITS-1:0] entry_value;
   logic [sts_pkg::CODE_BITS-1:0] sample;
   logic                          accept, out_free, start, wen;
   logic [sts_pkg::LH_W-1:0]      length;
   logic [ADDR_W-1:0]             raddr;
   logic [SAMPLE_BITS-1:0]        rdata;
   sts_pkg::search_stat_type      stat;

   // unpack the request beat
   assign entry_index = req_tdata[6:0];
   assign entry_value = req_tdata[18:7];
   assign sample      = req_tdata[30:19];

   assign req_tready = stat.idle;
   assign accept     = req_tvalid && req_tready;
   assign start      = accept && (req_tuser == sts_pkg::CMD_LOOKUP);
   assign wen        = accept && (req_tuser == sts_pkg::CMD_LOAD)
                       && (int'(entry_index) < TABLE_DEPTH);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // entries in use, clipped to the table depth
   assign length = (int'(len_ff) > TABLE_DEPTH) ? sts_pkg::LH_W'(TABLE_DEPTH)
                                                : sts_pkg::LH_W'(len_ff);

   // length register and result register
   always_comb begin
      len_in       = len_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      if (csr_wen) begin
         len_in = csr_wdata;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (stat.done && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = stat.index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= sts_pkg::LEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_index_ff <= rsp_index_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_index_ff;

   sts_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .wen   (wen),
      .waddr (ADDR_W'(entry_index)),
      .wdata (SAMPLE_BITS'(entry_value)),
      .raddr (raddr),
      .rdata (rdata)
   );

   sts_search #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_search (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .key      (SAMPLE_BITS'(sample)),
      .length   (length),
      .out_free (out_free),
      .rdata    (rdata),
      .raddr    (raddr),
      .stat     (stat)
   );

endmodule

>>> hw/rtl/sts_check.sv
`include "sorted_table_floor_search_macros.svh"

module sts_check (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic                         req_tuser,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [sts_pkg::RES_BITS-1:0] rsp_tdata
);

   logic lookup_beat, load_beat, rsp_stall;

   // handshake events
   assign lookup_beat = req_tvalid && req_tready && (req_tuser == sts_pkg::CMD_LOOKUP);
   assign load_beat   = req_tvalid && req_tready && (req_tuser == sts_pkg::CMD_LOAD);
   assign rsp_stall   = rsp_tvalid && !rsp_tready;

   // a stalled result beat holds
   `STS_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_tdata), "result changed")

   // after a lookup is taken, the request side is not ready in the following cycle
   `STS_ASSERT_NEXT(a_lookup_busy, lookup_beat, !req_tready, "request taken after a lookup")

   // a load never starts a search
   `STS_ASSERT_NEXT(a_load_free, load_beat, req_tready, "load beat blocked the request side")

   // a new result appears only as the search hands back the request side
   `STS_ASSERT_NOW(a_result_idle, $rose(rsp_tvalid), req_tready, "result raised while searching")

endmodule

bind sorted_table_floor_search sts_check u_check (.*);
